@@ rtl/assert_macros.svh @@
// Assertion macros shared by the timer bank RTL.
// Files that check their own logic pull this header in by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MCST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mcst_pkg.sv @@
// Package for the multi-channel timer bank: widths, request codes,
// controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps

package mcst_pkg;

    localparam int TIME_W    = 32;
    localparam int MASK_W    = 8;
    localparam int REQ_W     = 3;
    localparam int CHAN_W    = 3;
    localparam int IN_DATA_W = 72;   // channel + period + now, padded to bytes
    localparam int OUT_DATA_W = 48;  // fired + running + nearest
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;

    localparam logic [REQ_W-1:0] REQ_TICK           = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET_PERIOD     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_START_ONCE     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_START_PERIODIC = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DISABLE        = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK_CHK,
        ST_DIV_RUN,
        ST_NEAR_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch_req;
        logic apply_req;
        logic idx_clr;
        logic idx_inc;
        logic tick_upd;
        logic div_start;
        logic div_upd;
        logic near_clr;
        logic near_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic need_div;
        logic idx_last;
        logic div_done;
    } t_sts;

endpackage

@@ rtl/multi_channel_soft_timer_bank_unit.sv @@
// One request word at a time: a new word is accepted only when the controller is idle, after the
// per-channel tick check, any catch-up runs of the remainder unit and the nearest-deadline scan
// over the channel registers. A synchronous active-low reset clears all channels at once.
// Top level: stream ports, controller and datapath. Depends on mcst_pkg,
// mcst_ctrl and mcst_dpath.
`timescale 1ns / 1ps

module multi_channel_soft_timer_bank_unit #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [2:0] channel, [34:3] period_ms, [66:35] now_ms, [71:67] zero
    input  logic [mcst_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [2:0] req_type
    input  logic [mcst_pkg::REQ_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] fired_mask, [15:8] running_mask, [47:16] nearest_ms
    output logic [mcst_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] nearest_valid
    output logic                            m_axis_tuser
);

    mcst_pkg::t_cmd              w_cmd;
    mcst_pkg::t_sts              w_sts;
    logic                        w_in_ready;
    logic [mcst_pkg::MASK_W-1:0] w_fired;
    logic [mcst_pkg::MASK_W-1:0] w_running;
    logic [mcst_pkg::TIME_W-1:0] w_nearest;
    logic                        w_have;

    mcst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mcst_dpath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_req_type      (s_axis_tuser),
        .i_channel       (s_axis_tdata[2:0]),
        .i_period_ms     (s_axis_tdata[34:3]),
        .i_now_ms        (s_axis_tdata[66:35]),
        .o_fired_mask    (w_fired),
        .o_running_mask  (w_running),
        .o_nearest_ms    (w_nearest),
        .o_nearest_valid (w_have)
    );

    assign s_axis_tready = w_in_ready;
    assign m_axis_tdata  = {w_nearest, w_running, w_fired};
    assign m_axis_tuser  = w_have;

endmodule

@@ rtl/mcst_div.sv @@
// Restoring remainder unit: one quotient bit per cycle.
// Depends on mcst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcst_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mcst_pkg::TIME_W-1:0] i_dividend,
    input  logic [mcst_pkg::TIME_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [mcst_pkg::TIME_W-1:0] o_rem
);

    logic                           r_busy;
    logic                           r_done;
    logic [mcst_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [mcst_pkg::TIME_W-1:0]    r_rem;
    logic [mcst_pkg::TIME_W-1:0]    r_dvd;
    logic [mcst_pkg::TIME_W-1:0]    r_dsr;
    logic [mcst_pkg::TIME_W:0]      w_shift;
    logic [mcst_pkg::TIME_W:0]      w_diff;

    assign w_shift = {r_rem, r_dvd[mcst_pkg::TIME_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == mcst_pkg::DIV_CNT_W'(mcst_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            // subtract when the shifted partial remainder covers the divisor
            if (!w_diff[mcst_pkg::TIME_W]) begin
                r_rem <= w_diff[mcst_pkg::TIME_W-1:0];
            end else begin
                r_rem <= w_shift[mcst_pkg::TIME_W-1:0];
            end
            r_dvd <= {r_dvd[mcst_pkg::TIME_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    `MCST_ASSERT_NOW(a_rem_below_divisor, i_clk, i_rst_n, r_done, r_rem < r_dsr, "remainder not below divisor")
    `MCST_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy && !r_done, "divider did not start")

endmodule

@@ rtl/mcst_ctrl.sv @@
// Controller FSM: sequences decode, per-channel tick check, catch-up division,
// nearest-deadline scan and result handoff. Depends on mcst_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  mcst_pkg::t_sts   i_sts,
    output mcst_pkg::t_cmd   o_cmd
);

    mcst_pkg::t_state r_state;
    mcst_pkg::t_state n_state;
    logic             r_out_valid;
    mcst_pkg::t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mcst_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            mcst_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.latch_req = 1'b1;
                    n_state         = mcst_pkg::ST_DECODE;
                end
            end
            mcst_pkg::ST_DECODE: begin
                w_cmd.idx_clr = 1'b1;
                if (i_sts.is_tick) begin
                    n_state = mcst_pkg::ST_TICK_CHK;
                end else begin
                    w_cmd.apply_req = 1'b1;
                    w_cmd.near_clr  = 1'b1;
                    n_state         = mcst_pkg::ST_NEAR_SCAN;
                end
            end
            mcst_pkg::ST_TICK_CHK: begin
                if (i_sts.need_div) begin
                    w_cmd.div_start = 1'b1;
                    n_state         = mcst_pkg::ST_DIV_RUN;
                end else begin
                    w_cmd.tick_upd = 1'b1;
                    if (i_sts.idx_last) begin
                        w_cmd.idx_clr  = 1'b1;
                        w_cmd.near_clr = 1'b1;
                        n_state        = mcst_pkg::ST_NEAR_SCAN;
                    end else begin
                        w_cmd.idx_inc = 1'b1;
                    end
                end
            end
            mcst_pkg::ST_DIV_RUN: begin
                if (i_sts.div_done) begin
                    w_cmd.div_upd = 1'b1;
                    if (i_sts.idx_last) begin
                        w_cmd.idx_clr  = 1'b1;
                        w_cmd.near_clr = 1'b1;
                        n_state        = mcst_pkg::ST_NEAR_SCAN;
                    end else begin
                        w_cmd.idx_inc = 1'b1;
                        n_state       = mcst_pkg::ST_TICK_CHK;
                    end
                end
            end
            mcst_pkg::ST_NEAR_SCAN: begin
                w_cmd.near_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = mcst_pkg::ST_DONE;
                end else begin
                    w_cmd.idx_inc = 1'b1;
                end
            end
            mcst_pkg::ST_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = mcst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mcst_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == mcst_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    `MCST_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, !r_out_valid || i_out_ready, "pending word overwritten")

endmodule

@@ rtl/mcst_dpath.sv @@
// Datapath: channel storage, request registers, tick update, nearest scan
// and output word register. Depends on mcst_pkg and mcst_div.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcst_dpath #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mcst_pkg::t_cmd              i_cmd,
    output mcst_pkg::t_sts              o_sts,
    input  logic [mcst_pkg::REQ_W-1:0]  i_req_type,
    input  logic [mcst_pkg::CHAN_W-1:0] i_channel,
    input  logic [mcst_pkg::TIME_W-1:0] i_period_ms,
    input  logic [mcst_pkg::TIME_W-1:0] i_now_ms,
    output logic [mcst_pkg::MASK_W-1:0] o_fired_mask,
    output logic [mcst_pkg::MASK_W-1:0] o_running_mask,
    output logic [mcst_pkg::TIME_W-1:0] o_nearest_ms,
    output logic                        o_nearest_valid
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [mcst_pkg::TIME_W-1:0] r_period   [NUM_CHANNELS];
    logic [mcst_pkg::TIME_W-1:0] r_deadline [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]     r_active;
    logic [NUM_CHANNELS-1:0]     r_repeat;

    logic [mcst_pkg::REQ_W-1:0]  r_req;
    logic                        r_chan_ok;
    logic [mcst_pkg::TIME_W-1:0] r_period_in;
    logic [mcst_pkg::TIME_W-1:0] r_now;
    logic [IDX_W-1:0]            r_idx;

    logic [mcst_pkg::MASK_W-1:0] r_fired;
    logic [mcst_pkg::MASK_W-1:0] r_running;
    logic [mcst_pkg::TIME_W-1:0] r_nearest;
    logic [mcst_pkg::TIME_W-1:0] r_best;
    logic                        r_have;

    logic [mcst_pkg::MASK_W-1:0] r_out_fired;
    logic [mcst_pkg::MASK_W-1:0] r_out_running;
    logic [mcst_pkg::TIME_W-1:0] r_out_nearest;
    logic                        r_out_have;

    logic                        w_chan_ok;
    logic [mcst_pkg::TIME_W-1:0] w_p;
    logic [mcst_pkg::TIME_W-1:0] w_d;
    logic [mcst_pkg::TIME_W-1:0] w_e;
    logic [mcst_pkg::TIME_W-1:0] w_gap;
    logic                        w_hit;
    logic                        w_in_mask;
    logic                        w_need_div;
    logic                        w_div_done;
    logic [mcst_pkg::TIME_W-1:0] w_rem;
    logic [mcst_pkg::TIME_W-1:0] w_catch_up;

    assign w_chan_ok  = (32'(i_channel) < NUM_CHANNELS);
    assign w_p        = r_period[r_idx];
    assign w_d        = r_deadline[r_idx];
    assign w_e        = r_now - w_d;
    assign w_gap      = w_d - r_now;
    assign w_hit      = r_active[r_idx] && !w_e[mcst_pkg::TIME_W-1];
    assign w_in_mask  = (32'(r_idx) < mcst_pkg::MASK_W);
    assign w_need_div = w_hit && r_repeat[r_idx] && (w_p != '0) && (w_e != '0);
    // next deadline is the first period boundary at or after the current time
    assign w_catch_up = (w_rem == '0) ? r_now : (r_now + (w_p - w_rem));

    mcst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_e),
        .i_divisor  (w_p),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    always_comb begin
        o_sts          = '0;
        o_sts.is_tick  = (r_req == mcst_pkg::REQ_TICK);
        o_sts.need_div = w_need_div;
        o_sts.idx_last = (r_idx == IDX_W'(NUM_CHANNELS - 1));
        o_sts.div_done = w_div_done;
    end

    // request word and scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_req       <= i_req_type;
            r_chan_ok   <= w_chan_ok;
            r_period_in <= i_period_ms;
            r_now       <= i_now_ms;
            r_idx       <= w_chan_ok ? IDX_W'(i_channel) : '0;
        end else if (i_cmd.idx_clr && !i_cmd.apply_req) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_period[c]   <= '0;
                r_deadline[c] <= '0;
            end
            r_active <= '0;
            r_repeat <= '0;
        end else if (i_cmd.apply_req && r_chan_ok) begin
            unique case (r_req)
                mcst_pkg::REQ_SET_PERIOD: begin
                    r_period[r_idx] <= r_period_in;
                end
                mcst_pkg::REQ_START_ONCE, mcst_pkg::REQ_START_PERIODIC: begin
                    r_repeat[r_idx]   <= (r_req == mcst_pkg::REQ_START_PERIODIC);
                    r_deadline[r_idx] <= r_now + w_p;
                    r_active[r_idx]   <= 1'b1;
                end
                mcst_pkg::REQ_DISABLE: begin
                    r_active[r_idx] <= 1'b0;
                    r_repeat[r_idx] <= 1'b0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.tick_upd && w_hit) begin
            if (!r_repeat[r_idx]) begin
                r_active[r_idx] <= 1'b0;
            end else if (w_p == '0) begin
                // periodic with no period: disarm
                r_active[r_idx] <= 1'b0;
                r_repeat[r_idx] <= 1'b0;
            end else begin
                // deadline exactly now: advance one period
                r_deadline[r_idx] <= r_now + w_p;
            end
        end else if (i_cmd.div_upd) begin
            r_deadline[r_idx] <= w_catch_up;
        end
    end

    // fired mask and nearest scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_fired <= '0;
        end else if ((i_cmd.tick_upd && w_hit) || i_cmd.div_upd) begin
            if (w_in_mask) begin
                r_fired[3'(r_idx)] <= 1'b1;
            end
        end
        if (i_cmd.near_clr) begin
            r_running <= '0;
            r_nearest <= '0;
            r_best    <= '0;
            r_have    <= 1'b0;
        end else if (i_cmd.near_step && r_active[r_idx]) begin
            if (w_in_mask) begin
                r_running[3'(r_idx)] <= 1'b1;
            end
            if (!r_have || ($signed(w_gap) < $signed(r_best))) begin
                r_have    <= 1'b1;
                r_best    <= w_gap;
                r_nearest <= w_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_fired   <= r_fired;
            r_out_running <= r_running;
            r_out_nearest <= r_nearest;
            r_out_have    <= r_have;
        end
    end

    assign o_fired_mask    = r_out_fired;
    assign o_running_mask  = r_out_running;
    assign o_nearest_ms    = r_out_nearest;
    assign o_nearest_valid = r_out_have;

    `MCST_ASSERT_NOW(a_no_skipped_div, i_clk, i_rst_n, i_cmd.tick_upd, !w_need_div, "catch-up division skipped")
    `MCST_ASSERT_NEXT(a_scan_sets_have, i_clk, i_rst_n, i_cmd.near_step && r_active[r_idx], r_have, "active channel missed by scan")

endmodule
